### hw/rtl/assert_macros.svh
// Assertion macros shared by the LFO bank RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LFOB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define LFOB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lfob_pkg.sv
// Shared constants, codes and types of the triangle LFO bank.
// Depends on nothing; imported by the bank module and its testbench.
package lfob_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int RATE_STEPS_DEF = 128;
    localparam int STORE_DEPTH    = 2048;
    localparam int STORE_AW       = 11;

    localparam logic [7:0] UNSET_VALUE  = 8'hFF;
    localparam logic [7:0] DEFAULT_RATE = 8'd64;
    localparam logic [7:0] NOT_FOUND    = 8'hFF;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_REG   = 3'd1;
    localparam logic [2:0] OP_QUERY = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    localparam logic [1:0] KIND_CC    = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef logic [3:0] chan_t;
    typedef logic [6:0] ctrl_t;

endpackage

### hw/rtl/lfob_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the controller store and the rate table.
module lfob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/triangle_lfo_bank.sv
// Triangle LFO bank: SLOTS slots, controller store and rate table in RAM.
// Register, query, set and load transactions each give one result. A tick walks the slots:
// a running slot passes through scan, rate and update states, a stopped slot through scan
// and rate, a free slot through scan only, and an end state closes the walk; the store and
// rate table reads are registered and done in turn; a result still waiting at the output
// stalls the walk until it is taken. After reset a pass fills the controller store with 255 (unset).
// Reset is synchronous and active low and clears the control state and slot active flags.
module triangle_lfo_bank
    import lfob_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int RATE_STEPS = RATE_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [3:0]  s_channel,
    input  logic [6:0]  s_controller,
    input  logic [6:0]  s_min_value,
    input  logic [6:0]  s_max_value,
    input  logic [6:0]  s_start_value,
    input  logic [3:0]  s_rate_channel,
    input  logic [6:0]  s_rate_controller,
    input  logic [6:0]  s_value,
    input  logic [6:0]  s_rate_index,
    input  logic [15:0] s_rate_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_out_channel,
    output logic [6:0]  m_out_controller,
    output logic [7:0]  m_out_value,
    output logic        m_last
);
    `include "assert_macros.svh"

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = $clog2(RATE_STEPS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_RATE  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_END   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [STORE_AW-1:0] clr_reg;
    logic [IW-1:0]       idx_reg;
    logic                m_valid_reg;
    logic [1:0]          kind_reg;
    chan_t               och_reg;
    ctrl_t               occ_reg;
    logic [7:0]          oval_reg;
    logic                last_reg;

    logic [SLOTS-1:0] active_reg;
    chan_t            ch_reg   [SLOTS];
    ctrl_t            cc_reg   [SLOTS];
    logic [6:0]       pos_reg  [SLOTS];
    logic [6:0]       lo_reg   [SLOTS];
    logic [6:0]       hi_reg   [SLOTS];
    logic [SLOTS-1:0] fall_reg;
    chan_t            rch_reg  [SLOTS];
    ctrl_t            rcc_reg  [SLOTS];
    logic [15:0]      cnt_reg  [SLOTS];

    logic          out_free, accept, last_slot;
    logic          hit_found, free_found;
    logic [IW-1:0] hit_idx, free_idx, reg_idx;
    logic [7:0]    store_rdata, rate_eff;
    logic [15:0]   table_rdata, cnt_inc;
    logic          stopped, step;
    logic [RW-1:0] rate_sat;
    logic [6:0]    pos_new, start_clamped;
    logic          fall_new, upd_go;

    logic                st_we, st_re, rt_we, rt_re;
    logic [STORE_AW-1:0] st_waddr, st_raddr;
    logic [7:0]          st_wdata;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign last_slot = (idx_reg == IW'(SLOTS - 1));

    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (active_reg[i] && ch_reg[i] == s_channel && cc_reg[i] == s_controller) begin
                hit_found = 1'b1;
                hit_idx   = IW'(i);
            end
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign reg_idx = hit_found ? hit_idx : free_idx;
    assign start_clamped = (s_start_value < s_min_value) ? s_min_value :
                           ((s_start_value > s_max_value) ? s_max_value : s_start_value);

    assign rate_eff = (store_rdata == UNSET_VALUE) ? DEFAULT_RATE : store_rdata;
    assign stopped  = (rate_eff == 8'd0);
    assign rate_sat = ({1'b0, rate_eff} >= 9'(RATE_STEPS)) ? RW'(RATE_STEPS - 1)
                                                           : RW'(rate_eff);

    assign cnt_inc = cnt_reg[idx_reg] + 16'd1;
    assign step    = !(cnt_inc < table_rdata);
    assign upd_go  = (state_reg == ST_UPD) && out_free;

    always_comb begin
        pos_new  = pos_reg[idx_reg];
        fall_new = fall_reg[idx_reg];
        if (!fall_reg[idx_reg] && pos_reg[idx_reg] >= hi_reg[idx_reg]) begin
            fall_new = 1'b1;
        end else if (fall_reg[idx_reg] && pos_reg[idx_reg] <= lo_reg[idx_reg]) begin
            fall_new = 1'b0;
        end else if (!fall_reg[idx_reg]) begin
            pos_new = pos_reg[idx_reg] + 7'd1;
        end else begin
            pos_new = pos_reg[idx_reg] - 7'd1;
        end
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = {ch_reg[idx_reg], cc_reg[idx_reg]};
        st_wdata = {1'b0, pos_new};
        if (state_reg == ST_CLEAR) begin
            st_we    = 1'b1;
            st_waddr = clr_reg;
            st_wdata = UNSET_VALUE;
        end else if (accept) begin
            st_we    = (s_operation == OP_SET);
            st_waddr = {s_channel, s_controller};
            st_wdata = {1'b0, s_value};
        end else if (upd_go && step) begin
            st_we = 1'b1;
        end
    end

    assign st_re    = (state_reg == ST_SCAN) && active_reg[idx_reg];
    assign st_raddr = {rch_reg[idx_reg], rcc_reg[idx_reg]};
    assign rt_we    = accept && (s_operation == OP_LOAD);
    assign rt_re    = (state_reg == ST_RATE) && !stopped;

    lfob_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (store_rdata)
    );

    lfob_ram #(.WIDTH(16), .DEPTH(RATE_STEPS)) u_rate (
        .aclk  (aclk),
        .we    (rt_we),
        .waddr (RW'(s_rate_index)),
        .wdata (s_rate_ticks),
        .re    (rt_re),
        .raddr (rate_sat),
        .rdata (table_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == {STORE_AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && s_operation == OP_TICK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (active_reg[idx_reg]) begin
                    state_next = ST_RATE;
                end else if (last_slot) begin
                    state_next = ST_END;
                end
            end
            ST_RATE: begin
                if (!stopped) begin
                    state_next = ST_UPD;
                end else if (last_slot) begin
                    state_next = ST_END;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    state_next = last_slot ? ST_END : ST_SCAN;
                end
            end
            ST_END: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            active_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                idx_reg     <= '0;
                m_valid_reg <= (s_operation != OP_TICK);
                kind_reg    <= KIND_END;
                och_reg     <= '0;
                occ_reg     <= '0;
                oval_reg    <= '0;
                last_reg    <= 1'b1;
                if (s_operation == OP_QUERY) begin
                    kind_reg <= KIND_QUERY;
                    och_reg  <= s_channel;
                    occ_reg  <= s_controller;
                    oval_reg <= hit_found ? {1'b0, pos_reg[hit_idx]} : NOT_FOUND;
                end
                if (s_operation == OP_REG && (hit_found || free_found)) begin
                    if (!hit_found) begin
                        active_reg[reg_idx] <= 1'b1;
                        ch_reg[reg_idx]     <= s_channel;
                        cc_reg[reg_idx]     <= s_controller;
                        pos_reg[reg_idx]    <= start_clamped;
                        fall_reg[reg_idx]   <= 1'b0;
                    end
                    lo_reg[reg_idx]  <= s_min_value;
                    hi_reg[reg_idx]  <= s_max_value;
                    rch_reg[reg_idx] <= s_rate_channel;
                    rcc_reg[reg_idx] <= s_rate_controller;
                    cnt_reg[reg_idx] <= '0;
                end
            end
            if ((state_reg == ST_SCAN && !active_reg[idx_reg] && !last_slot) ||
                (state_reg == ST_RATE && stopped && !last_slot) ||
                (upd_go && !last_slot)) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (upd_go) begin
                if (step) begin
                    cnt_reg[idx_reg]  <= '0;
                    pos_reg[idx_reg]  <= pos_new;
                    fall_reg[idx_reg] <= fall_new;
                    m_valid_reg       <= 1'b1;
                    kind_reg          <= KIND_CC;
                    och_reg           <= ch_reg[idx_reg];
                    occ_reg           <= cc_reg[idx_reg];
                    oval_reg          <= {1'b0, pos_new};
                    last_reg          <= 1'b0;
                end else begin
                    cnt_reg[idx_reg] <= cnt_inc;
                end
            end
            if (state_reg == ST_END && out_free) begin
                m_valid_reg <= 1'b1;
                kind_reg    <= KIND_END;
                och_reg     <= '0;
                occ_reg     <= '0;
                oval_reg    <= '0;
                last_reg    <= 1'b1;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_out_channel    = och_reg;
    assign m_out_controller = occ_reg;
    assign m_out_value      = oval_reg;
    assign m_last           = last_reg;

    `LFOB_ASSERT_IMP(a_no_accept_in_clear, aclk, aresetn,
        state_reg == ST_CLEAR, !s_ready, "Transaction accepted during the store clear.")
    `LFOB_ASSERT_IMP(a_upd_slot_active, aclk, aresetn,
        state_reg == ST_UPD || state_reg == ST_RATE, active_reg[idx_reg],
        "Tick update on an inactive slot.")
    `LFOB_ASSERT_IMP(a_end_is_last, aclk, aresetn,
        m_valid && m_kind == KIND_END, m_last, "End of item without last.")
    `LFOB_ASSERT_NEXT(a_end_to_idle, aclk, aresetn,
        state_reg == ST_END && out_free, state_reg == ST_IDLE && m_valid && m_last,
        "Tick did not close with an end-of-item result.")
endmodule

### tb/tb_triangle_lfo_bank.sv
// Self-checking testbench for the triangle LFO bank: drives random and directed
// transactions, predicts each result with a behavioral model and compares them.
// Depends on lfob_pkg and triangle_lfo_bank.
`timescale 1ns / 100ps

module tb_triangle_lfo_bank;
    import lfob_pkg::*;

    localparam int NSLOT = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] chan;
        logic [6:0] ctrl;
        logic [7:0] val;
        logic       last;
    } lfo_msg_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = '0;
    logic [3:0]  s_channel = '0;
    logic [6:0]  s_controller = '0;
    logic [6:0]  s_min_value = '0;
    logic [6:0]  s_max_value = '0;
    logic [6:0]  s_start_value = '0;
    logic [3:0]  s_rate_channel = '0;
    logic [6:0]  s_rate_controller = '0;
    logic [6:0]  s_value = '0;
    logic [6:0]  s_rate_index = '0;
    logic [15:0] s_rate_ticks = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [3:0]  m_out_channel;
    logic [6:0]  m_out_controller;
    logic [7:0]  m_out_value;
    logic        m_last;

    triangle_lfo_bank i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted bank state.
    logic        lfo_on [NSLOT];
    logic [3:0]  lfo_chan [NSLOT];
    logic [6:0]  lfo_ctrl [NSLOT];
    logic [6:0]  lfo_pos [NSLOT];
    logic [6:0]  lfo_lo [NSLOT];
    logic [6:0]  lfo_hi [NSLOT];
    logic        lfo_down [NSLOT];
    logic [3:0]  lfo_rchan [NSLOT];
    logic [6:0]  lfo_rctrl [NSLOT];
    logic [15:0] lfo_count [NSLOT];
    logic [7:0]  cc_store [2048];
    logic [15:0] divisor [128];

    lfo_msg_t    pending_msgs [$];
    int          errors = 0;
    int          sent = 0;
    int          checked = 0;
    int          cc_seen = 0;
    int          hold_off = 0;
    int          rx_wait = 0;
    int          max_gap = 11;

    function automatic int find_lfo(logic [3:0] ch, logic [6:0] cc);
        for (int i = 0; i < NSLOT; i++)
            if (lfo_on[i] && lfo_chan[i] == ch && lfo_ctrl[i] == cc) return i;
        return -1;
    endfunction

    function automatic bit advance_lfo(int i);
        logic [7:0]  rate;
        logic [16:0] cnt;
        rate = cc_store[{lfo_rchan[i], lfo_rctrl[i]}];
        if (rate == UNSET_VALUE) rate = DEFAULT_RATE;
        if (rate == 0) return 0;
        if (rate > 127) rate = 127;
        cnt = {1'b0, lfo_count[i]} + 1;
        lfo_count[i] = cnt[15:0];
        if (cnt[15:0] < divisor[rate[6:0]]) return 0;
        lfo_count[i] = '0;
        if (!lfo_down[i] && lfo_pos[i] >= lfo_hi[i]) lfo_down[i] = 1'b1;
        else if (lfo_down[i] && lfo_pos[i] <= lfo_lo[i]) lfo_down[i] = 1'b0;
        else if (!lfo_down[i]) lfo_pos[i] = lfo_pos[i] + 1;
        else lfo_pos[i] = lfo_pos[i] - 1;
        cc_store[{lfo_chan[i], lfo_ctrl[i]}] = {1'b0, lfo_pos[i]};
        return 1;
    endfunction

    task automatic predict_bank(input logic [2:0] op, input logic [3:0] ch,
                                input logic [6:0] cc, input logic [6:0] lo,
                                input logic [6:0] hi, input logic [6:0] st,
                                input logic [3:0] rch, input logic [6:0] rcc,
                                input logic [6:0] val, input logic [6:0] idx,
                                input logic [15:0] ticks);
        int i;
        i = -1;
        case (op)
            OP_TICK: begin
                for (int k = 0; k < NSLOT; k++)
                    if (lfo_on[k] && advance_lfo(k))
                        pending_msgs.push_back({KIND_CC, lfo_chan[k], lfo_ctrl[k],
                                                {1'b0, lfo_pos[k]}, 1'b0});
            end
            OP_REG: begin
                i = find_lfo(ch, cc);
                if (i < 0) begin
                    for (int k = NSLOT - 1; k >= 0; k--) if (!lfo_on[k]) i = k;
                    if (i >= 0) begin
                        lfo_on[i] = 1'b1;
                        lfo_chan[i] = ch;
                        lfo_ctrl[i] = cc;
                        lfo_pos[i] = (st < lo) ? lo : ((st > hi) ? hi : st);
                        lfo_down[i] = 1'b0;
                    end
                end
                if (i >= 0) begin
                    lfo_lo[i] = lo;
                    lfo_hi[i] = hi;
                    lfo_rchan[i] = rch;
                    lfo_rctrl[i] = rcc;
                    lfo_count[i] = '0;
                end
            end
            OP_QUERY: begin
                i = find_lfo(ch, cc);
                pending_msgs.push_back({KIND_QUERY, ch, cc,
                    (i < 0) ? NOT_FOUND : {1'b0, lfo_pos[i]}, 1'b1});
            end
            OP_SET: cc_store[{ch, cc}] = {1'b0, val};
            OP_LOAD: divisor[idx] = ticks;
            default: ;
        endcase
        if (op != OP_QUERY) pending_msgs.push_back({KIND_END, 4'd0, 7'd0, 8'd0, 1'b1});
    endtask

    task automatic send_item(input logic [2:0] op, input logic [3:0] ch,
                             input logic [6:0] cc, input logic [6:0] lo,
                             input logic [6:0] hi, input logic [6:0] st,
                             input logic [3:0] rch, input logic [6:0] rcc,
                             input logic [6:0] val, input logic [6:0] idx,
                             input logic [15:0] ticks);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_channel <= ch;
        s_controller <= cc;
        s_min_value <= lo;
        s_max_value <= hi;
        s_start_value <= st;
        s_rate_channel <= rch;
        s_rate_controller <= rcc;
        s_value <= val;
        s_rate_index <= idx;
        s_rate_ticks <= ticks;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_bank(op, ch, cc, lo, hi, st, rch, rcc, val, idx, ticks);
        sent++;
    endtask

    task automatic do_tick();
        send_item(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic do_reg(logic [3:0] ch, logic [6:0] cc, logic [6:0] lo,
                          logic [6:0] hi, logic [6:0] st, logic [3:0] rch,
                          logic [6:0] rcc);
        send_item(OP_REG, ch, cc, lo, hi, st, rch, rcc, $urandom, $urandom, $urandom);
    endtask

    task automatic do_query(logic [3:0] ch, logic [6:0] cc);
        send_item(OP_QUERY, ch, cc, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic do_set(logic [3:0] ch, logic [6:0] cc, logic [6:0] val);
        send_item(OP_SET, ch, cc, $urandom, $urandom, $urandom, $urandom,
                  $urandom, val, $urandom, $urandom);
    endtask

    task automatic do_load(logic [6:0] idx, logic [15:0] ticks);
        send_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, idx, ticks);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_msgs.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        lfo_msg_t want;
        if (aresetn && m_valid && m_ready) begin
            checked++;
            if (pending_msgs.size() == 0) begin
                report_mismatch("unexpected transaction, kind", m_kind, -1);
            end else begin
                want = pending_msgs.pop_front();
                if (m_kind == KIND_CC) cc_seen++;
                if (m_kind !== want.kind) report_mismatch("kind", m_kind, want.kind);
                if (m_out_channel !== want.chan)
                    report_mismatch("channel", m_out_channel, want.chan);
                if (m_out_controller !== want.ctrl)
                    report_mismatch("controller", m_out_controller, want.ctrl);
                if (m_out_value !== want.val)
                    report_mismatch("value", m_out_value, want.val);
                if (m_last !== want.last) report_mismatch("last", m_last, want.last);
            end
        end
    end

    // Receiver back-pressure: a random wait is drawn for every result.
    always @(posedge aclk) begin
        int rx_draw;
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            rx_draw = $urandom_range(0, 11);
            if (rx_draw == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_wait <= rx_draw - 1;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every rate entry is loaded first so no unwritten entry is ever read.
    task automatic test_rate_table();
        for (int r = 0; r < 128; r++) begin
            if (r == 0) do_load(7'd0, 16'hFFFF);
            else do_load(r[6:0], 16'(r % 4));
        end
        do_load(7'd127, 16'd0);
        do_load(7'd64, 16'd1);
        do_load(7'd1, 16'd2);
        wait_drained();
    endtask

    task automatic test_directed();
        do_query(4'd0, 7'd0);
        do_reg(4'd0, 7'd0, 7'd10, 7'd12, 7'd0, 4'd15, 7'd127);
        do_reg(4'd15, 7'd127, 7'd0, 7'd127, 7'd127, 4'd15, 7'd126);
        do_reg(4'd3, 7'd5, 7'd20, 7'd10, 7'd15, 4'd1, 7'd1);
        do_reg(4'd4, 7'd6, 7'd0, 7'd2, 7'd100, 4'd1, 7'd2);
        do_set(4'd1, 7'd2, 7'd0);
        do_set(4'd15, 7'd126, 7'd127);
        do_set(4'd1, 7'd1, 7'd1);
        repeat (6) do_tick();
        do_reg(4'd0, 7'd0, 7'd0, 7'd127, 7'd50, 4'd0, 7'd9);
        do_query(4'd0, 7'd0);
        do_query(4'd15, 7'd127);
        for (int k = 0; k < 6; k++) do_reg(4'd9, 7'(k + 40), 7'd1, 7'd3, 7'd2, 4'd0, 7'd0);
        send_item(3'd5, 4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 4'd0, 7'd0, 7'd0, 7'd0, 16'd0);
        send_item(3'd7, 4'd15, 7'd127, 7'd127, 7'd127, 7'd127, 4'd15, 7'd127,
                  7'd127, 7'd127, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_random();
        int pick;
        for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) do_tick();
            else if (pick < 6) do_reg($urandom_range(0, 2), $urandom_range(0, 3),
                $urandom, $urandom, $urandom, $urandom_range(0, 1),
                $urandom_range(0, 3));
            else if (pick < 7) do_query($urandom_range(0, 2), $urandom_range(0, 3));
            else if (pick < 9) do_set($urandom_range(0, 1), $urandom_range(0, 3),
                $urandom);
            else if (pick == 9) do_load($urandom, $urandom_range(0, 3));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 200;
        max_gap = 0;
        repeat (10) do_tick();
        max_gap = 11;
        wait_drained();
        repeat (3) do_tick();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (lfo_on[i]) lfo_on[i] = 1'b0;
        foreach (cc_store[i]) cc_store[i] = UNSET_VALUE;
        foreach (divisor[i]) divisor[i] = '0;
        test_rate_table();
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (100) @(posedge aclk);
        $display("Sent %0d transactions, checked %0d results, %0d control changes.",
                 sent, checked, cc_seen);
        if (errors == 0 && pending_msgs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding.", pending_msgs.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
